/* rtl/tord_pkg.sv */
// Shared types and constants for the tour orientation ring solver.
package tord_pkg;

    // Command codes carried by the command field of an input beat
    localparam logic [1:0] CMD_HOP_WRITE   = 2'd0;
    localparam logic [1:0] CMD_ORDER_WRITE = 2'd1;
    localparam logic [1:0] CMD_RUN         = 2'd2;

    // Fixed field widths
    localparam int EP_W       = 6;
    localparam int SEG_W      = 5;
    localparam int LEN_W      = 24;
    localparam int HOP_IN_W   = 24;
    localparam int CNT_IN_W   = 6;
    localparam int POS_W      = 5;
    localparam int TOTAL_W    = 32;
    localparam int HOP_ADDR_W = 2 * EP_W;
    localparam int HOP_DEPTH  = 1 << HOP_ADDR_W;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_ORD,
        S_HOP,
        S_STEP_END,
        S_CLOSE,
        S_PASS_END,
        S_DECIDE,
        S_TOTAL,
        S_BACK,
        S_EMIT
    } state_t;

endpackage

/* rtl/tour_orientation_ring_dp.sv */
// Ring orientation solver: cost stores, two-state ring DP sequencer and result stage.
//
//  channel | direction | handshake                 | beat carries
//  --------+-----------+---------------------------+----------------------------------------
//  item    | in        | item_valid / item_stall   | command, hop write, order write or run
//  result  | out       | result_valid / result_stall | out_position, entry_side, feasible,
//          |           |                           | total_cost, last
//
// Hop cost and order slot writes are taken one per cycle while idle. A run with N segments holds
// item_stall high through its work and any result stalls: it sums the lengths, then per start
// side runs the DP steps and the closing hop, all paced by the single read port of the hop
// cost memory (four reads a step), then backtracks over the positions and loads the result
// beats. Reset clears the sequencer and the result stage only; the stores hold whatever was
// last written. A stalled result beat holds; the input reopens once the last is loaded.
module tour_orientation_ring_dp #(
    parameter int MAX_SEGMENTS = 32,
    parameter int COST_BITS    = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [1:0]                        command,
    input  logic [tord_pkg::EP_W-1:0]         from_endpoint,
    input  logic [tord_pkg::EP_W-1:0]         to_endpoint,
    input  logic [tord_pkg::HOP_IN_W-1:0]     hop_cost,
    input  logic                              hop_blocked,
    input  logic [tord_pkg::POS_W-1:0]        position,
    input  logic [tord_pkg::SEG_W-1:0]        segment,
    input  logic [tord_pkg::LEN_W-1:0]        segment_length,
    input  logic [tord_pkg::CNT_IN_W-1:0]     count,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [tord_pkg::POS_W-1:0]        out_position,
    output logic                              entry_side,
    output logic                              feasible,
    output logic [tord_pkg::TOTAL_W-1:0]      total_cost,
    output logic                              last
);
    import tord_pkg::*;

    localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNTW  = $clog2(MAX_SEGMENTS + 1);
    localparam int SUM_W = LEN_W + CNTW;
    localparam int DPW   = COST_BITS + CNTW;
    localparam int MAXW  = (SUM_W > DPW) ? SUM_W : DPW;
    localparam int TW    = ((MAXW > TOTAL_W) ? MAXW : TOTAL_W) + 1;
    localparam int HW    = COST_BITS + 1;
    localparam int OW    = SEG_W + LEN_W;

    // Stores
    logic [HW-1:0]          hop_mem [HOP_DEPTH];
    logic [OW-1:0]          ord_mem [MAX_SEGMENTS];
    logic [3:0]             bp_reg  [MAX_SEGMENTS];

    // Memory ports
    logic                   hop_we;
    logic                   hop_re;
    logic [HOP_ADDR_W-1:0]  hop_waddr;
    logic [HOP_ADDR_W-1:0]  hop_raddr;
    logic [HW-1:0]          hop_wdata;
    logic [HW-1:0]          hop_rdata_reg;
    logic                   ord_we;
    logic                   ord_re;
    logic [AW-1:0]          ord_waddr;
    logic [AW-1:0]          ord_raddr;
    logic [OW-1:0]          ord_wdata;
    logic [OW-1:0]          ord_rdata_reg;
    logic                   bp_we;
    logic [AW-1:0]          bp_waddr;
    logic [TOTAL_W-1:0]     hop_cost_ext;

    // Sequencer and working registers
    state_t                 state_reg, state_next;
    logic [CNTW-1:0]        idx_reg, idx_next;
    logic [CNTW-1:0]        n_reg, n_next;
    logic [2:0]             ph_reg, ph_next;
    logic                   pend_reg, pend_next;
    logic [CNTW-1:0]        pend_idx_reg, pend_idx_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SEG_W-1:0]       seg0_reg, seg0_next;
    logic [SEG_W-1:0]       segl_reg, segl_next;
    logic [SEG_W-1:0]       si_reg, si_next;
    logic                   st_reg, st_next;
    logic [DPW-1:0]         c_reg [2];
    logic [DPW-1:0]         c_next [2];
    logic [DPW-1:0]         nc_reg [2];
    logic [DPW-1:0]         nc_next [2];
    logic [1:0]             ok_reg, ok_next;
    logic [1:0]             nok_reg, nok_next;
    logic [1:0]             bp_step_reg, bp_step_next;
    logic                   found_reg, found_next;
    logic [DPW-1:0]         best_reg, best_next;
    logic                   last_side_reg, last_side_next;
    logic                   f1_reg, f1_next;
    logic [DPW-1:0]         best1_reg, best1_next;
    logic                   last1_reg, last1_next;
    logic                   use1_reg, use1_next;
    logic [DPW-1:0]         bestsel_reg, bestsel_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [MAX_SEGMENTS-1:0] side_reg, side_next;
    logic                   infeas_reg, infeas_next;

    // Result stage
    logic                   result_valid_reg, result_valid_next;
    logic [POS_W-1:0]       out_position_reg, out_position_next;
    logic                   entry_side_reg, entry_side_next;
    logic                   feasible_reg, feasible_next;
    logic [TOTAL_W-1:0]     total_cost_reg, total_cost_next;
    logic                   last_reg, last_next;

    // Helpers
    logic                   take_item;
    logic                   out_free;
    logic [SEG_W-1:0]       rd_seg;
    logic [LEN_W-1:0]       rd_len;
    logic                   rd_blk;
    logic [DPW-1:0]         rd_cost;
    logic                   last_step;
    logic                   back_done;
    logic                   emit_last;

    assign take_item    = item_valid && !item_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign rd_seg       = ord_rdata_reg[OW-1:LEN_W];
    assign rd_len       = ord_rdata_reg[LEN_W-1:0];
    assign rd_blk       = hop_rdata_reg[HW-1];
    assign rd_cost      = DPW'(hop_rdata_reg[COST_BITS-1:0]);
    assign last_step    = (CNTW'(idx_reg + 1'b1) == CNTW'(n_reg - 1'b1));
    assign back_done    = (idx_reg == '0);
    assign emit_last    = infeas_reg || (idx_reg == CNTW'(n_reg - 1'b1));
    assign hop_cost_ext = TOTAL_W'(hop_cost);

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign out_position = out_position_reg;
    assign entry_side   = entry_side_reg;
    assign feasible     = feasible_reg;
    assign total_cost   = total_cost_reg;
    assign last         = last_reg;

    // Hop cost memory: written only while idle, read only during a run
    always_ff @(posedge clk)
    begin
        if (hop_we)
        begin
            hop_mem[hop_waddr] <= hop_wdata;
        end
        if (hop_re)
        begin
            hop_rdata_reg <= hop_mem[hop_raddr];
        end
    end

    // Order and length memory, one slot per position
    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        if (ord_re)
        begin
            ord_rdata_reg <= ord_mem[ord_raddr];
        end
    end

    // Back pointers: two bits per start side, bit ej holds the best previous side
    always_ff @(posedge clk)
    begin
        if (bp_we)
        begin
            bp_reg[bp_waddr][{st_reg, 1'b0} +: 2] <= bp_step_reg;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take_item && command == CMD_RUN)
                begin
                    state_next = (count == '0) ? S_EMIT : S_SUM;
                end
            end
            S_SUM:
            begin
                if (idx_reg == n_reg && !pend_reg)
                begin
                    state_next = (n_reg == CNTW'(1)) ? S_CLOSE : S_ORD;
                end
            end
            S_ORD:
            begin
                state_next = S_HOP;
            end
            S_HOP:
            begin
                if (ph_reg == 3'd4)
                begin
                    state_next = S_STEP_END;
                end
            end
            S_STEP_END:
            begin
                state_next = last_step ? S_CLOSE : S_ORD;
            end
            S_CLOSE:
            begin
                if (ph_reg == 3'd2)
                begin
                    state_next = S_PASS_END;
                end
            end
            S_PASS_END:
            begin
                if (!st_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = (n_reg == CNTW'(1)) ? S_CLOSE : S_ORD;
                end
            end
            S_DECIDE:
            begin
                state_next = (!found_reg && !f1_reg) ? S_EMIT : S_TOTAL;
            end
            S_TOTAL:
            begin
                state_next = S_BACK;
            end
            S_BACK:
            begin
                if (back_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free && emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        logic             begin_pass;
        logic             pass_side;
        logic             ei;
        logic             ej;
        logic [1:0]       pp;
        logic [DPW-1:0]   cand;
        logic [TW-1:0]    total_wide;
        logic             use1;
        logic             cur;

        begin_pass        = 1'b0;
        pass_side         = 1'b0;
        ei                = 1'b0;
        ej                = 1'b0;
        pp                = 2'(ph_reg - 3'd1);
        cand              = '0;
        total_wide        = '0;
        use1              = 1'b0;
        cur               = 1'b0;

        hop_we            = 1'b0;
        hop_waddr         = {from_endpoint, to_endpoint};
        hop_wdata         = {hop_blocked, hop_cost_ext[COST_BITS-1:0]};
        hop_re            = 1'b0;
        hop_raddr         = '0;
        ord_we            = 1'b0;
        ord_waddr         = AW'(position);
        ord_wdata         = {segment, segment_length};
        ord_re            = 1'b0;
        ord_raddr         = idx_reg[AW-1:0];
        bp_we             = 1'b0;
        bp_waddr          = AW'(idx_reg + 1'b1);

        idx_next          = idx_reg;
        n_next            = n_reg;
        ph_next           = ph_reg;
        pend_next         = pend_reg;
        pend_idx_next     = pend_idx_reg;
        sum_next          = sum_reg;
        seg0_next         = seg0_reg;
        segl_next         = segl_reg;
        si_next           = si_reg;
        st_next           = st_reg;
        c_next            = c_reg;
        nc_next           = nc_reg;
        ok_next           = ok_reg;
        nok_next          = nok_reg;
        bp_step_next      = bp_step_reg;
        found_next        = found_reg;
        best_next         = best_reg;
        last_side_next    = last_side_reg;
        f1_next           = f1_reg;
        best1_next        = best1_reg;
        last1_next        = last1_reg;
        use1_next         = use1_reg;
        bestsel_next      = bestsel_reg;
        total_next        = total_reg;
        side_next         = side_reg;
        infeas_next       = infeas_reg;

        result_valid_next = result_valid_reg && result_stall;
        out_position_next = out_position_reg;
        entry_side_next   = entry_side_reg;
        feasible_next     = feasible_reg;
        total_cost_next   = total_cost_reg;
        last_next         = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                // Take store writes at once; latch the run length
                if (take_item)
                begin
                    if (command == CMD_HOP_WRITE)
                    begin
                        hop_we = 1'b1;
                    end
                    else if (command == CMD_ORDER_WRITE)
                    begin
                        ord_we = (32'(position) < MAX_SEGMENTS);
                    end
                    else if (command == CMD_RUN)
                    begin
                        n_next      = (32'(count) > MAX_SEGMENTS) ? CNTW'(MAX_SEGMENTS)
                                                                  : CNTW'(count);
                        infeas_next = (count == '0);
                        idx_next    = '0;
                        pend_next   = 1'b0;
                        sum_next    = '0;
                        f1_next     = 1'b0;
                    end
                end
            end
            S_SUM:
            begin
                // Stream the slots, add the lengths, keep first and last segment
                pend_next = 1'b0;
                if (idx_reg < n_reg)
                begin
                    ord_re        = 1'b1;
                    ord_raddr     = idx_reg[AW-1:0];
                    idx_next      = idx_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                end
                if (pend_reg)
                begin
                    sum_next = sum_reg + SUM_W'(rd_len);
                    if (pend_idx_reg == '0)
                    begin
                        seg0_next = rd_seg;
                    end
                    if (pend_idx_reg == CNTW'(n_reg - 1'b1))
                    begin
                        segl_next = rd_seg;
                    end
                end
                if (idx_reg == n_reg && !pend_reg)
                begin
                    begin_pass = 1'b1;
                    pass_side  = 1'b1;
                end
            end
            S_ORD:
            begin
                // Fetch the segment of the next position
                ord_re       = 1'b1;
                ord_raddr    = AW'(idx_reg + 1'b1);
                nok_next     = 2'b00;
                nc_next[0]   = '0;
                nc_next[1]   = '0;
                bp_step_next = 2'b00;
                ph_next      = '0;
            end
            S_HOP:
            begin
                // Issue the four hop reads, fold each one in as it returns
                if (ph_reg < 3'd4)
                begin
                    ei        = ph_reg[1];
                    ej        = ph_reg[0];
                    hop_re    = 1'b1;
                    hop_raddr = {si_reg, ~ei, rd_seg, ej};
                end
                if (ph_reg != 3'd0)
                begin
                    cand = c_reg[pp[1]] + rd_cost;
                    if (ok_reg[pp[1]] && !rd_blk &&
                        (!nok_reg[pp[0]] || cand < nc_reg[pp[0]]))
                    begin
                        nok_next[pp[0]]     = 1'b1;
                        nc_next[pp[0]]      = cand;
                        bp_step_next[pp[0]] = pp[1];
                    end
                end
                ph_next = ph_reg + 3'd1;
            end
            S_STEP_END:
            begin
                // Advance one position and record its back pointers
                c_next   = nc_reg;
                ok_next  = nok_reg;
                bp_we    = 1'b1;
                bp_waddr = AW'(idx_reg + 1'b1);
                si_next  = rd_seg;
                idx_next = idx_reg + 1'b1;
                ph_next  = '0;
            end
            S_CLOSE:
            begin
                // Closing hop from the last position back to the start side
                if (ph_reg < 3'd2)
                begin
                    ei        = ph_reg[0];
                    hop_re    = 1'b1;
                    hop_raddr = {segl_reg, ~ei, seg0_reg, st_reg};
                end
                if (ph_reg != 3'd0)
                begin
                    cand = c_reg[pp[0]] + rd_cost;
                    if (ok_reg[pp[0]] && !rd_blk && (!found_reg || cand < best_reg))
                    begin
                        found_next     = 1'b1;
                        best_next      = cand;
                        last_side_next = pp[0];
                    end
                end
                ph_next = ph_reg + 3'd1;
            end
            S_PASS_END:
            begin
                // Keep the start side one result and rerun from side zero
                if (st_reg)
                begin
                    f1_next    = found_reg;
                    best1_next = best_reg;
                    last1_next = last_side_reg;
                    begin_pass = 1'b1;
                    pass_side  = 1'b0;
                end
            end
            S_DECIDE:
            begin
                // Pick the cheaper start side, side zero on a tie
                use1 = !found_reg || (f1_reg && best1_reg < best_reg);
                if (!found_reg && !f1_reg)
                begin
                    infeas_next = 1'b1;
                end
                use1_next    = use1;
                bestsel_next = use1 ? best1_reg : best_reg;
                side_next[AW'(n_reg - 1'b1)] = use1 ? last1_reg : last_side_reg;
                idx_next     = CNTW'(n_reg - 1'b1);
            end
            S_TOTAL:
            begin
                // Add lengths and hops, saturate to 32 bits
                total_wide = TW'(sum_reg) + TW'(bestsel_reg);
                total_next = (total_wide[TW-1:TOTAL_W] != '0) ? '1
                                                              : total_wide[TOTAL_W-1:0];
            end
            S_BACK:
            begin
                // Walk back one position per cycle
                if (!back_done)
                begin
                    cur = side_reg[idx_reg[AW-1:0]];
                    side_next[AW'(idx_reg - 1'b1)] = bp_reg[idx_reg[AW-1:0]][{use1_reg, cur}];
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_EMIT:
            begin
                // Load one result beat whenever the output register frees up
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    if (infeas_reg)
                    begin
                        out_position_next = '0;
                        entry_side_next   = 1'b0;
                        feasible_next     = 1'b0;
                        total_cost_next   = '0;
                        last_next         = 1'b1;
                    end
                    else
                    begin
                        out_position_next = POS_W'(idx_reg);
                        entry_side_next   = side_reg[idx_reg[AW-1:0]];
                        feasible_next     = 1'b1;
                        total_cost_next   = total_reg;
                        last_next         = emit_last;
                        idx_next          = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                result_valid_next = 1'b0;
            end
        endcase

        // Start a DP pass from the given side
        if (begin_pass)
        begin
            st_next        = pass_side;
            ok_next        = pass_side ? 2'b10 : 2'b01;
            c_next[0]      = '0;
            c_next[1]      = '0;
            found_next     = 1'b0;
            best_next      = '0;
            last_side_next = 1'b0;
            si_next        = seg0_reg;
            idx_next       = '0;
            ph_next        = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            pend_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            pend_reg         <= pend_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        idx_reg          <= idx_next;
        n_reg            <= n_next;
        ph_reg           <= ph_next;
        pend_idx_reg     <= pend_idx_next;
        sum_reg          <= sum_next;
        seg0_reg         <= seg0_next;
        segl_reg         <= segl_next;
        si_reg           <= si_next;
        st_reg           <= st_next;
        c_reg            <= c_next;
        nc_reg           <= nc_next;
        ok_reg           <= ok_next;
        nok_reg          <= nok_next;
        bp_step_reg      <= bp_step_next;
        found_reg        <= found_next;
        best_reg         <= best_next;
        last_side_reg    <= last_side_next;
        f1_reg           <= f1_next;
        best1_reg        <= best1_next;
        last1_reg        <= last1_next;
        use1_reg         <= use1_next;
        bestsel_reg      <= bestsel_next;
        total_reg        <= total_next;
        side_reg         <= side_next;
        infeas_reg       <= infeas_next;
        out_position_reg <= out_position_next;
        entry_side_reg   <= entry_side_next;
        feasible_reg     <= feasible_next;
        total_cost_reg   <= total_cost_next;
        last_reg         <= last_next;
    end

    // A run beat closes the input until its results are out
    assert property (@(posedge clk) disable iff (!rst_n)
        take_item && command == CMD_RUN |=> item_stall)
        else $error("input open right after a run beat");

    // An infeasible result is the single, last beat at position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !feasible |-> last && out_position == '0)
        else $error("infeasible result not a lone final beat");

    // Beats of one run follow position by position with a common total
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !last |=>
            result_valid && out_position == POS_W'($past(out_position) + 1'b1) &&
            total_cost == $past(total_cost))
        else $error("result beats out of sequence");

endmodule

/* bench/tb_tour_orientation_ring_dp.sv */
// Self-checking bench for the tour orientation ring solver: cost loads, runs and result beats.
module tb_tour_orientation_ring_dp;
    import tord_pkg::*;

    localparam int MAX_SEG            = 32;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT     = 5000;
    localparam int SETTLE_CYCLES      = 40;
    localparam int REPORT_LIMIT       = 10;

    // One result beat: the entry side of one position of the tour
    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic               side;
        logic               feas;
        logic [TOTAL_W-1:0] total;
        logic               is_last;
    } leg_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                item_valid     = 1'b0;
    logic                item_stall;
    logic [1:0]          command        = CMD_HOP_WRITE;
    logic [EP_W-1:0]     from_endpoint  = '0;
    logic [EP_W-1:0]     to_endpoint    = '0;
    logic [HOP_IN_W-1:0] hop_cost       = '0;
    logic                hop_blocked    = 1'b0;
    logic [POS_W-1:0]    position       = '0;
    logic [SEG_W-1:0]    segment        = '0;
    logic [LEN_W-1:0]    segment_length = '0;
    logic [CNT_IN_W-1:0] count          = '0;
    logic                result_valid;
    logic                result_stall   = 1'b0;
    logic [POS_W-1:0]    out_position;
    logic                entry_side;
    logic                feasible;
    logic [TOTAL_W-1:0]  total_cost;
    logic                last;

    // Shadow copy of the stores, with a mark on every entry that has been written
    logic [24:0]         hop_cost_mem [HOP_DEPTH];
    bit                  hop_known    [HOP_DEPTH];
    logic [SEG_W-1:0]    seg_order    [MAX_SEG];
    logic [LEN_W-1:0]    seg_len      [MAX_SEG];
    bit                  slot_known   [MAX_SEG];
    leg_t                awaited_legs [$];

    int mismatches    = 0;
    int legs_checked  = 0;
    int runs_solved   = 0;
    int runs_open     = 0;
    int load_beats    = 0;
    int ignored_beats = 0;
    int useful_beats  = 0;
    int stall_burst   = 0;
    int quiet_cycles  = 0;
    bit idle_on       = 1'b1;

    tour_orientation_ring_dp i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .command        (command),
        .from_endpoint  (from_endpoint),
        .to_endpoint    (to_endpoint),
        .hop_cost       (hop_cost),
        .hop_blocked    (hop_blocked),
        .position       (position),
        .segment        (segment),
        .segment_length (segment_length),
        .count          (count),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .out_position   (out_position),
        .entry_side     (entry_side),
        .feasible       (feasible),
        .total_cost     (total_cost),
        .last           (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Address of the hop leaving segment si (entered at ei) into segment sj entered at ej
    function automatic logic [HOP_ADDR_W-1:0] hop_addr(logic [SEG_W-1:0] si, bit ei,
                                                        logic [SEG_W-1:0] sj, bit ej);
        return {si, ~ei, sj, ej};
    endfunction

    // Append one expected result beat to the tail of the queue
    function automatic void await_leg(input leg_t leg);
        awaited_legs = {awaited_legs, leg};
    endfunction

    // Sweep the ring once from a fixed start side; return 1 if the tour closes
    function automatic bit ring_sweep(input bit st, input int n,
                                      output bit [1:0] links [MAX_SEG],
                                      output longint unsigned best, output bit exit_side);
        longint unsigned acc [2];
        longint unsigned nxt [2];
        bit              reach [2];
        bit              nreach [2];
        logic [24:0]     entry;
        bit              found;
        found     = 1'b0;
        best      = 0;
        exit_side = 1'b0;
        for (int i = 0; i < MAX_SEG; i++)
            links[i] = 2'b00;
        acc[0]   = 0;
        acc[1]   = 0;
        reach[0] = !st;
        reach[1] = st;
        for (int k = 0; k + 1 < n; k++)
        begin
            nreach[0] = 1'b0;
            nreach[1] = 1'b0;
            nxt[0]    = 0;
            nxt[1]    = 0;
            for (int ei = 0; ei < 2; ei++)
            begin
                if (reach[ei])
                begin
                    for (int ej = 0; ej < 2; ej++)
                    begin
                        entry = hop_cost_mem[hop_addr(seg_order[k], ei[0],
                                                      seg_order[k + 1], ej[0])];
                        // lower previous side wins a tie
                        if (!entry[24] && (!nreach[ej] || acc[ei] + entry[23:0] < nxt[ej]))
                        begin
                            nreach[ej]     = 1'b1;
                            nxt[ej]        = acc[ei] + entry[23:0];
                            links[k+1][ej] = ei[0];
                        end
                    end
                end
            end
            acc   = nxt;
            reach = nreach;
        end
        // close the ring back onto the start side
        for (int ei = 0; ei < 2; ei++)
        begin
            entry = hop_cost_mem[hop_addr(seg_order[n - 1], ei[0], seg_order[0], st)];
            if (reach[ei] && !entry[24] && (!found || acc[ei] + entry[23:0] < best))
            begin
                found     = 1'b1;
                best      = acc[ei] + entry[23:0];
                exit_side = ei[0];
            end
        end
        return found;
    endfunction

    // Solve a run and queue the result beats it should produce
    function automatic void orient_tour(input logic [CNT_IN_W-1:0] cnt);
        int              n;
        longint unsigned len_total;
        longint unsigned best0;
        longint unsigned best1;
        longint unsigned total;
        bit              f0;
        bit              f1;
        bit              last0;
        bit              last1;
        bit              from_one;
        bit [1:0]        links0 [MAX_SEG];
        bit [1:0]        links1 [MAX_SEG];
        bit              side [MAX_SEG];
        leg_t            leg;
        n         = (cnt > MAX_SEG) ? MAX_SEG : int'(cnt);
        len_total = 0;
        best0     = 0;
        best1     = 0;
        f0        = 1'b0;
        f1        = 1'b0;
        last0     = 1'b0;
        last1     = 1'b0;
        for (int k = 0; k < n; k++)
            len_total += 64'(seg_len[k]);
        if (n > 0)
        begin
            f1 = ring_sweep(1'b1, n, links1, best1, last1);
            f0 = ring_sweep(1'b0, n, links0, best0, last0);
        end
        // no closed tour: a single empty beat
        if (!f0 && !f1)
        begin
            leg         = '0;
            leg.is_last = 1'b1;
            await_leg(leg);
            runs_open++;
            return;
        end
        from_one    = !f0 || (f1 && best1 < best0);
        total       = len_total + (from_one ? best1 : best0);
        if (total > 64'hFFFF_FFFF)
            total = 64'hFFFF_FFFF;
        side[n - 1] = from_one ? last1 : last0;
        for (int k = n - 1; k >= 1; k--)
            side[k - 1] = from_one ? links1[k][side[k]] : links0[k][side[k]];
        for (int k = 0; k < n; k++)
        begin
            leg.pos     = k[POS_W-1:0];
            leg.side    = side[k];
            leg.feas    = 1'b1;
            leg.total   = total[TOTAL_W-1:0];
            leg.is_last = (k == n - 1);
            await_leg(leg);
        end
        runs_solved++;
    endfunction

    // Small values to provoke ties, near-full values for the top of the range
    function automatic logic [HOP_IN_W-1:0] pick_distance();
        logic [HOP_IN_W-1:0] v;
        v = HOP_IN_W'($urandom);
        case ($urandom_range(0, 3))
            0: v = v & 24'h00_0003;
            1: v = v | 24'hFF_FFFC;
            default: ;
        endcase
        return v;
    endfunction

    function automatic bit pick_block();
        return ($urandom_range(0, 4) == 0);
    endfunction

    // Drive one beat, hold it until taken, then update the shadow stores
    task automatic send_beat(input logic [1:0] cmd, input logic [EP_W-1:0] src_ep,
                             input logic [EP_W-1:0] dst_ep, input logic [HOP_IN_W-1:0] cost,
                             input logic blk, input logic [POS_W-1:0] pos,
                             input logic [SEG_W-1:0] seg, input logic [LEN_W-1:0] len,
                             input logic [CNT_IN_W-1:0] cnt);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        item_valid     <= 1'b1;
        command        <= cmd;
        from_endpoint  <= src_ep;
        to_endpoint    <= dst_ep;
        hop_cost       <= cost;
        hop_blocked    <= blk;
        position       <= pos;
        segment        <= seg;
        segment_length <= len;
        count          <= cnt;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        case (cmd)
            CMD_HOP_WRITE:
            begin
                hop_cost_mem[{src_ep, dst_ep}] = {blk, cost};
                hop_known[{src_ep, dst_ep}]    = 1'b1;
                load_beats++;
                useful_beats++;
            end
            CMD_ORDER_WRITE:
            begin
                seg_order[pos]  = seg;
                seg_len[pos]    = len;
                slot_known[pos] = 1'b1;
                load_beats++;
                useful_beats++;
            end
            CMD_RUN:
            begin
                orient_tour(cnt);
                useful_beats++;
            end
            default:
                ignored_beats++;
        endcase
    endtask

    task automatic write_hop(input logic [EP_W-1:0] src_ep, input logic [EP_W-1:0] dst_ep,
                             input logic [HOP_IN_W-1:0] cost, input logic blk);
        send_beat(CMD_HOP_WRITE, src_ep, dst_ep, cost, blk,
                  POS_W'($urandom), SEG_W'($urandom), LEN_W'($urandom),
                  CNT_IN_W'($urandom));
    endtask

    task automatic write_link(input logic [SEG_W-1:0] si, input bit ei,
                              input logic [SEG_W-1:0] sj, input bit ej,
                              input logic [HOP_IN_W-1:0] cost, input logic blk);
        logic [HOP_ADDR_W-1:0] a;
        a = hop_addr(si, ei, sj, ej);
        write_hop(a[11:6], a[5:0], cost, blk);
    endtask

    task automatic write_slot(input logic [POS_W-1:0] pos, input logic [SEG_W-1:0] seg,
                              input logic [LEN_W-1:0] len);
        send_beat(CMD_ORDER_WRITE, EP_W'($urandom), EP_W'($urandom), HOP_IN_W'($urandom),
                  1'($urandom), pos, seg, len, CNT_IN_W'($urandom));
    endtask

    task automatic run_tour(input logic [CNT_IN_W-1:0] cnt);
        send_beat(CMD_RUN, EP_W'($urandom), EP_W'($urandom), HOP_IN_W'($urandom),
                  1'($urandom), POS_W'($urandom), SEG_W'($urandom), LEN_W'($urandom), cnt);
    endtask

    task automatic send_noise();
        send_beat(CMD_UNUSED, EP_W'($urandom), EP_W'($urandom), HOP_IN_W'($urandom),
                  1'($urandom), POS_W'($urandom), SEG_W'($urandom), LEN_W'($urandom),
                  CNT_IN_W'($urandom));
    endtask

    // Hold the sender until every queued result beat has arrived
    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_legs.size() != 0);
    endtask

    // Write every slot and hop that a run over n positions may read and that is still blank
    task automatic fill_missing(input int n);
        logic [HOP_ADDR_W-1:0] a;
        int                    nx;
        for (int k = 0; k < n; k++)
            if (!slot_known[k])
                write_slot(POS_W'(k), SEG_W'($urandom), pick_distance());
        for (int k = 0; k < n; k++)
        begin
            nx = (k + 1) % n;
            for (int c = 0; c < 4; c++)
            begin
                a = hop_addr(seg_order[k], c[1], seg_order[nx], c[0]);
                if (!hop_known[a])
                    write_hop(a[11:6], a[5:0], pick_distance(), pick_block());
            end
        end
    endtask

    // Equal hop costs everywhere: start, previous and last side all fall to side 0
    task automatic test_tie_break();
        write_slot(5'd0, 5'd0, 24'hFF_FFFF);
        write_slot(5'd1, 5'd31, 24'h00_0000);
        for (int c = 0; c < 4; c++)
            write_link(5'd0, c[1], 5'd31, c[0], 24'd7, 1'b0);
        for (int c = 0; c < 4; c++)
            write_link(5'd31, c[1], 5'd0, c[0], 24'd7, 1'b0);
        run_tour(6'd2);
    endtask

    // Every closing hop blocked: a single infeasible beat
    task automatic test_no_closed_tour();
        for (int c = 0; c < 4; c++)
            write_link(5'd31, c[1], 5'd0, c[0], HOP_IN_W'($urandom), 1'b1);
        run_tour(6'd2);
    endtask

    // Closing hops at zero, at full scale, blocked and in between
    task automatic test_cost_extremes();
        write_link(5'd31, 1'b0, 5'd0, 1'b0, 24'h00_0000, 1'b0);
        write_link(5'd31, 1'b0, 5'd0, 1'b1, 24'hFF_FFFF, 1'b0);
        write_link(5'd31, 1'b1, 5'd0, 1'b0, 24'hFF_FFFF, 1'b1);
        write_link(5'd31, 1'b1, 5'd0, 1'b1, 24'd5, 1'b0);
        run_tour(6'd2);
    endtask

    // Unused command code leaves the stores alone
    task automatic test_ignored_beats();
        send_beat(CMD_UNUSED, '1, '1, '1, 1'b1, '1, '1, '1, '1);
        send_noise();
        run_tour(6'd2);
    endtask

    // Full ring of one repeated segment, counts at and beyond the limit, one and zero
    task automatic test_count_limits();
        logic [SEG_W-1:0] s;
        s = SEG_W'($urandom);
        for (int i = 0; i < MAX_SEG; i++)
            write_slot(POS_W'(i), s, (i == 0) ? 24'hFF_FFFF : pick_distance());
        for (int c = 0; c < 4; c++)
            write_link(s, c[1], s, c[0], pick_distance(), 1'b0);
        run_tour(6'd32);
        run_tour(6'd33);
        wait_drained();
        run_tour(6'd63);
        run_tour(6'd1);
        run_tour(6'd0);
    endtask

    // One random tour: a few edits, fill the gaps, then run it
    task automatic random_episode();
        int                  n;
        int                  k;
        int                  nx;
        logic [CNT_IN_W-1:0] cnt;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, MAX_SEG) : $urandom_range(1, 6);
        if (n <= 6 && $urandom_range(0, 3) == 0)
            for (int i = 0; i < n; i++)
                write_slot(POS_W'(i), SEG_W'($urandom), pick_distance());
        repeat ($urandom_range(0, 4))
        begin
            k  = $urandom_range(0, n - 1);
            nx = (k + 1) % n;
            case ($urandom_range(0, 4))
                0, 1:
                    if (slot_known[k] && slot_known[nx])
                        write_link(seg_order[k], 1'($urandom), seg_order[nx], 1'($urandom),
                                   pick_distance(), pick_block());
                2: write_slot(POS_W'(k), SEG_W'($urandom), pick_distance());
                3: write_hop(EP_W'($urandom), EP_W'($urandom), pick_distance(), pick_block());
                default: send_noise();
            endcase
        end
        fill_missing(n);
        cnt = CNT_IN_W'(n);
        if (n == MAX_SEG && $urandom_range(0, 1) == 1)
            cnt = CNT_IN_W'($urandom_range(MAX_SEG, 63));
        run_tour(cnt);
        if ($urandom_range(0, 5) == 0)
            wait_drained();
    endtask

    task automatic test_random_tours(input int budget);
        int target;
        target = useful_beats + budget;
        while (useful_beats < target)
            random_episode();
    endtask

    // Stall the result channel in random bursts
    always @(posedge clk)
    begin
        if (stall_burst != 0)
        begin
            stall_burst  <= stall_burst - 1;
            result_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_burst  <= $urandom_range(0, 16);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    function automatic void note_failure(string what, leg_t want, leg_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("[%0t] %s: expected pos %0d side %0b feas %0b total %0d last %0b",
                     $time, what, want.pos, want.side, want.feas, want.total, want.is_last);
            $display("[%0t] %s: got      pos %0d side %0b feas %0b total %0d last %0b",
                     $time, what, got.pos, got.side, got.feas, got.total, got.is_last);
        end
    endfunction

    // Check each accepted result beat against the oldest expectation
    always @(posedge clk)
    begin
        leg_t got;
        leg_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = {out_position, entry_side, feasible, total_cost, last};
            if (awaited_legs.size() == 0)
                note_failure("result beat with nothing expected", '0, got);
            else
            begin
                want = awaited_legs.pop_front();
                legs_checked++;
                if (got.pos !== want.pos || got.side !== want.side || got.feas !== want.feas
                    || got.total !== want.total || got.is_last !== want.is_last)
                    note_failure("result beat mismatch", want, got);
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL tour_orientation_ring_dp");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_tie_break();
        test_no_closed_tour();
        test_cost_extremes();
        test_ignored_beats();
        test_count_limits();
        test_random_tours(85);
        // quiet tail: no idling on either side
        idle_on <= 1'b0;
        test_random_tours(25);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_legs.size() != 0)
        begin
            $display("%0d expected result beats never arrived", awaited_legs.size());
            mismatches += awaited_legs.size();
        end
        $display("Solved %0d tours and %0d without a closed ring; %0d result beats checked.",
                 runs_solved, runs_open, legs_checked);
        $display("Sent %0d load beats and %0d ignored beats; %0d mismatches.",
                 load_beats, ignored_beats, mismatches);
        if (mismatches == 0)
            $display("PASS tour_orientation_ring_dp");
        else
            $display("FAIL tour_orientation_ring_dp");
        $finish;
    end

endmodule

/* tour_orientation_ring_dp.f */
rtl/tord_pkg.sv
rtl/tour_orientation_ring_dp.sv
bench/tb_tour_orientation_ring_dp.sv
